// ===== src/sha256sh_pkg.sv =====
// Package for the SHA-256 stream hasher: word types, sequencer states,
// round constants, initial hash values and the SHA-256 mixing functions.
// No dependencies.
`timescale 1ns / 1ps

package sha256sh_pkg;

  // Input word: four message bytes, byte count and end-of-message flag
  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  valid_bytes;
    logic        last_word;
  } in_word_t;

  // Output word: the 256-bit digest in four 64-bit parts
  typedef struct packed {
    logic [63:0] digest_part0;
    logic [63:0] digest_part1;
    logic [63:0] digest_part2;
    logic [63:0] digest_part3;
  } out_word_t;

  // Eight 32-bit hash words, word 0 in the top bits
  typedef logic [0:7][31:0]  hash_t;
  // Sixteen-word schedule window, word 0 is the one used this round
  typedef logic [0:15][31:0] sched_t;

  // Control from the sequencer to the compression unit
  typedef struct packed {
    logic        push;   // shift one word into the block buffer
    logic [31:0] word;
    logic        start;  // block buffer full: run 64 rounds
    logic        init;   // return the chaining state to its initial value
  } cmp_ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMP,
    S_PAD,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    PAD_NONE,
    PAD_MARK,
    PAD_FILL,
    PAD_LEN_LO,
    PAD_FINISH
  } pad_e;

  localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;
  localparam logic [3:0]  FILL_LAST     = 4'd15;
  localparam logic [3:0]  FILL_LEN_HI   = 4'd14;
  localparam logic [2:0]  BYTES_FULL    = 3'd4;
  localparam logic [5:0]  ROUND_LAST    = 6'd63;

  localparam hash_t INIT_HASH = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

// ===== src/sha256sh_compress.sv =====
// Iterative SHA-256 compression unit: one round per cycle through a single
// round datapath, block buffer as a 16-word shift window, chaining state.
// Depends on sha256sh_pkg.
`timescale 1ns / 1ps

module sha256sh_compress (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sha256sh_pkg::cmp_ctrl_t ctrl_i,
  output logic                   done_o,
  output sha256sh_pkg::hash_t    chain_o
);

  sha256sh_pkg::hash_t  chain_q, chain_d;
  sha256sh_pkg::hash_t  vars_q, vars_d;
  sha256sh_pkg::sched_t sched_q, sched_d;
  logic [5:0]           round_q, round_d;
  logic                 busy_q, busy_d;
  logic                 fin_q, fin_d;

  logic [31:0] t1, t2, w_next;

  // Round datapath and next schedule word
  always_comb begin
    t1 = vars_q[7] + sha256sh_pkg::big_sigma1(vars_q[4])
       + ((vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]))
       + sha256sh_pkg::ROUND_K[round_q] + sched_q[0];
    t2 = sha256sh_pkg::big_sigma0(vars_q[0])
       + ((vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]));
    w_next = sha256sh_pkg::small_sigma1(sched_q[14]) + sched_q[9]
           + sha256sh_pkg::small_sigma0(sched_q[1]) + sched_q[0];
  end

  // Next state of the unit
  always_comb begin
    chain_d = chain_q;
    vars_d  = vars_q;
    sched_d = sched_q;
    round_d = round_q;
    busy_d  = busy_q;
    fin_d   = 1'b0;
    if (ctrl_i.push) begin
      sched_d = {sched_q[1:15], ctrl_i.word};
    end
    if (ctrl_i.start) begin
      vars_d  = chain_q;
      round_d = '0;
      busy_d  = 1'b1;
    end else if (busy_q) begin
      vars_d  = {t1 + t2, vars_q[0], vars_q[1], vars_q[2],
                 vars_q[3] + t1, vars_q[4], vars_q[5], vars_q[6]};
      sched_d = {sched_q[1:15], w_next};
      round_d = round_q + 6'd1;
      if (round_q == sha256sh_pkg::ROUND_LAST) begin
        busy_d = 1'b0;
        fin_d  = 1'b1;
      end
    end
    // fold the working variables into the chaining state
    if (fin_q) begin
      for (int i = 0; i < 8; i++) begin
        chain_d[i] = chain_q[i] + vars_q[i];
      end
    end
    if (ctrl_i.init) begin
      chain_d = sha256sh_pkg::INIT_HASH;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q <= sha256sh_pkg::INIT_HASH;
      round_q <= '0;
      busy_q  <= 1'b0;
      fin_q   <= 1'b0;
    end else begin
      chain_q <= chain_d;
      round_q <= round_d;
      busy_q  <= busy_d;
      fin_q   <= fin_d;
    end
  end

  // Working variables and schedule window carry no reset
  always_ff @(posedge clk_i) begin
    vars_q  <= vars_d;
    sched_q <= sched_d;
  end

  assign done_o  = fin_q;
  assign chain_o = chain_q;

endmodule

// ===== src/sha256_stream_hasher.sv =====
// Top level of the SHA-256 stream hasher: word sequencer, hardware padding,
// bit-length counter and digest output register.
// Depends on sha256sh_pkg and sha256sh_compress.
//
// Usage: message words enter on the in channel (in_valid_i / in_stall_o),
// big-endian, first byte in bits 31..24. last_word marks the final word and
// valid_bytes (0..4, larger values taken as 4) says how many of its leading
// bytes belong to the message. The digest leaves on the out channel
// (out_valid_o / out_stall_i) as four 64-bit parts, one word per message.
// A word that does not complete a block is taken without stalling the input.
// The word that fills a 16-word block stalls the input while the 64 rounds
// run through the single shared round unit and the result is folded into
// the chaining state. After the final word the pad words enter one per cycle
// while no block is being compressed, one or two further blocks are
// compressed, and the digest is loaded into the output register after the
// last fold once that register is free. A digest that the
// receiver stalls is held; the block still takes the next message, and only
// the end of that message waits for the register to drain.
// Reset restores the initial hash values and clears length and fill.
`timescale 1ns / 1ps

module sha256_stream_hasher (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sha256sh_pkg::in_word_t  in_word_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sha256sh_pkg::out_word_t out_word_o
);

  sha256sh_pkg::state_e    state_q, state_d;
  sha256sh_pkg::pad_e      pad_q, pad_d;
  logic [3:0]              fill_q, fill_d;
  logic [63:0]             len_q, len_d;
  logic                    out_valid_q, out_valid_d;
  sha256sh_pkg::out_word_t out_word_q;

  sha256sh_pkg::cmp_ctrl_t ctrl;
  sha256sh_pkg::hash_t     chain;
  logic                    cmp_done;
  logic                    in_take;
  logic                    out_load;
  logic                    wrap;
  logic [2:0]              nbytes;
  logic [31:0]             last_padded;

  assign in_take = in_valid_i && (state_q == sha256sh_pkg::S_IDLE);
  // a push into the last slot completes the block
  assign wrap    = (in_take || (state_q == sha256sh_pkg::S_PAD)) &&
                   (fill_q == sha256sh_pkg::FILL_LAST);

  // Final word: clip the byte count, clear unused bytes, place the pad byte
  always_comb begin
    nbytes = (in_word_i.valid_bytes > sha256sh_pkg::BYTES_FULL) ?
             sha256sh_pkg::BYTES_FULL : in_word_i.valid_bytes;
    case (nbytes)
      3'd0:    last_padded = sha256sh_pkg::PAD_MARK_WORD;
      3'd1:    last_padded = {in_word_i.data_word[31:24], 24'h80_0000};
      3'd2:    last_padded = {in_word_i.data_word[31:16], 16'h8000};
      3'd3:    last_padded = {in_word_i.data_word[31:8], 8'h80};
      default: last_padded = in_word_i.data_word;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_stall_o = (state_q != sha256sh_pkg::S_IDLE);
    ctrl.push  = 1'b0;
    ctrl.word  = in_word_i.data_word;
    out_load   = 1'b0;
    case (state_q)
      sha256sh_pkg::S_IDLE: begin
        ctrl.push = in_take;
        if (in_word_i.last_word) begin
          ctrl.word = last_padded;
        end
      end
      sha256sh_pkg::S_PAD: begin
        ctrl.push = 1'b1;
        case (pad_q)
          sha256sh_pkg::PAD_MARK: ctrl.word = sha256sh_pkg::PAD_MARK_WORD;
          sha256sh_pkg::PAD_FILL: begin
            ctrl.word = (fill_q == sha256sh_pkg::FILL_LEN_HI) ? len_q[63:32] : 32'd0;
          end
          sha256sh_pkg::PAD_LEN_LO: ctrl.word = len_q[31:0];
          default: ctrl.word = 32'd0;
        endcase
      end
      sha256sh_pkg::S_OUT: out_load = !out_valid_q || !out_stall_i;
      default: ;
    endcase
    ctrl.start = wrap;
    ctrl.init  = out_load;
  end

  // Sequencer next state and padding phase
  always_comb begin
    state_d = state_q;
    pad_d   = pad_q;
    case (state_q)
      sha256sh_pkg::S_IDLE: begin
        if (in_take) begin
          if (in_word_i.last_word) begin
            pad_d = (nbytes == sha256sh_pkg::BYTES_FULL) ?
                    sha256sh_pkg::PAD_MARK : sha256sh_pkg::PAD_FILL;
          end
          if (wrap) begin
            state_d = sha256sh_pkg::S_COMP;
          end else if (in_word_i.last_word) begin
            state_d = sha256sh_pkg::S_PAD;
          end
        end
      end
      sha256sh_pkg::S_PAD: begin
        case (pad_q)
          sha256sh_pkg::PAD_MARK: pad_d = sha256sh_pkg::PAD_FILL;
          sha256sh_pkg::PAD_FILL: begin
            if (fill_q == sha256sh_pkg::FILL_LEN_HI) begin
              pad_d = sha256sh_pkg::PAD_LEN_LO;
            end
          end
          sha256sh_pkg::PAD_LEN_LO: pad_d = sha256sh_pkg::PAD_FINISH;
          default: pad_d = pad_q;
        endcase
        if (wrap) begin
          state_d = sha256sh_pkg::S_COMP;
        end
      end
      sha256sh_pkg::S_COMP: begin
        if (cmp_done) begin
          case (pad_q)
            sha256sh_pkg::PAD_NONE:   state_d = sha256sh_pkg::S_IDLE;
            sha256sh_pkg::PAD_FINISH: state_d = sha256sh_pkg::S_OUT;
            default:                  state_d = sha256sh_pkg::S_PAD;
          endcase
        end
      end
      sha256sh_pkg::S_OUT: begin
        if (out_load) begin
          state_d = sha256sh_pkg::S_IDLE;
          pad_d   = sha256sh_pkg::PAD_NONE;
        end
      end
      default: state_d = sha256sh_pkg::S_IDLE;
    endcase
  end

  // Fill count, bit length and output valid
  always_comb begin
    fill_d      = ctrl.push ? fill_q + 4'd1 : fill_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    if (in_take) begin
      len_d = len_q + (in_word_i.last_word ? {58'd0, nbytes, 3'b000} : 64'd32);
    end
    if (out_load) begin
      len_d       = '0;
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sha256sh_pkg::S_IDLE;
      pad_q       <= sha256sh_pkg::PAD_NONE;
      fill_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pad_q       <= pad_d;
      fill_q      <= fill_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Digest register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_word_q <= chain;
    end
  end

  sha256sh_compress u_compress (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (ctrl),
    .done_o  (cmp_done),
    .chain_o (chain)
  );

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== test/sha256_stream_hasher_chk.sv =====
// Checker for the SHA-256 stream hasher: watches both word channels, hashes the
// accepted message words itself and compares every digest the block returns.
// Depends on sha256sh_pkg for the channel word types.
`timescale 1ns / 1ps

module sha256_stream_hasher_chk (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  sha256sh_pkg::in_word_t  in_word_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  sha256sh_pkg::out_word_t out_word_i,
  output int                      fail_cnt_o,
  output int                      pending_o
);

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam int         BYTES_WORD = 4;
  localparam int         FILL_LEN   = 14;

  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Running message state
  logic [31:0] chain_h   [8];
  logic [31:0] block_buf [16];
  int          buf_fill;
  logic [63:0] msg_bits;

  // Digests still owed by the block, oldest first
  sha256sh_pkg::out_word_t digest_q [$];
  logic                    digest_done;
  sha256sh_pkg::out_word_t digest_calc;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic clear_msg();
    for (int i = 0; i < 8; i++) chain_h[i] = SHA_IV[i];
    for (int i = 0; i < 16; i++) block_buf[i] = '0;
    buf_fill = 0;
    msg_bits = '0;
  endtask

  // One full 64-round compression of the block buffer into the chain
  task automatic compress_buf();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] s0, s1, t1, t2;
    for (int r = 0; r < 16; r++) w[r] = block_buf[r];
    for (int r = 16; r < 64; r++) begin
      s0 = rotr(w[r-15], 7) ^ rotr(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = rotr(w[r-2], 17) ^ rotr(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = chain_h[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[r] + w[r];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endtask

  task automatic absorb(input logic [31:0] w);
    block_buf[buf_fill] = w;
    buf_fill = (buf_fill + 1) % 16;
    if (buf_fill == 0) compress_buf();
  endtask

  // Take one message word; on the last one pad, finish and produce the digest
  task automatic hash_word(input sha256sh_pkg::in_word_t iw, output logic done,
                           output sha256sh_pkg::out_word_t dg);
    int          nb;
    logic [31:0] keep;
    done = 1'b0;
    dg   = '0;
    if (!iw.last_word) begin
      msg_bits += 64'd32;
      absorb(iw.data_word);
    end else begin
      nb = (iw.valid_bytes > BYTES_WORD) ? BYTES_WORD : int'(iw.valid_bytes);
      msg_bits += 64'(nb) * 64'd8;
      if (nb == BYTES_WORD) begin
        absorb(iw.data_word);
        absorb({PAD_BYTE, 24'd0});
      end else begin
        // a shift by the full width leaves no byte kept
        keep = 32'hffff_ffff << (32 - 8 * nb);
        absorb((iw.data_word & keep) | ({24'd0, PAD_BYTE} << (24 - 8 * nb)));
      end
      while (buf_fill != FILL_LEN) absorb('0);
      absorb(msg_bits[63:32]);
      absorb(msg_bits[31:0]);
      dg = '{digest_part0: {chain_h[0], chain_h[1]}, digest_part1: {chain_h[2], chain_h[3]},
             digest_part2: {chain_h[4], chain_h[5]}, digest_part3: {chain_h[6], chain_h[7]}};
      done = 1'b1;
      clear_msg();
    end
  endtask

  task automatic check_digest(input sha256sh_pkg::out_word_t got);
    sha256sh_pkg::out_word_t want;
    logic [63:0]             w_part [4];
    logic [63:0]             g_part [4];
    if (digest_q.size() == 0) begin
      $display("%0t: unexpected digest %h", $time, got);
      fail_cnt_o++;
    end else begin
      want = digest_q.pop_front();
      w_part = '{want.digest_part0, want.digest_part1, want.digest_part2, want.digest_part3};
      g_part = '{got.digest_part0, got.digest_part1, got.digest_part2, got.digest_part3};
      for (int i = 0; i < 4; i++) begin
        if (w_part[i] !== g_part[i]) begin
          $display("%0t: digest_part%0d expected %h actual %h", $time, i, w_part[i], g_part[i]);
          fail_cnt_o++;
        end
      end
    end
  endtask

  // Results are checked before the same edge's input word is taken
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_msg();
      digest_q.delete();
      fail_cnt_o = 0;
      pending_o  = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_digest(out_word_i);
      if (in_valid_i && !in_stall_i) begin
        hash_word(in_word_i, digest_done, digest_calc);
        if (digest_done) digest_q.push_back(digest_calc);
      end
      pending_o = digest_q.size();
    end
  end

endmodule

// ===== test/sha256_stream_hasher_tb.sv =====
// Testbench top for the SHA-256 stream hasher: clock, reset, message stimulus
// and digest-side stalling; the checking is done by sha256_stream_hasher_chk.
// Depends on sha256sh_pkg, sha256_stream_hasher and sha256_stream_hasher_chk.
`timescale 1ns / 1ps

module sha256_stream_hasher_tb;

  localparam int NUM_WORDS  = 750;
  localparam int QUIET_TAIL = 100;
  localparam int HOLD_CYC   = 600;
  localparam int DRAIN_MAX  = 20000;
  localparam int TAIL_CYC   = 200;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  sha256sh_pkg::in_word_t  in_word_i   = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  sha256sh_pkg::out_word_t out_word_o;

  int        fail_cnt;
  int        digests_owed;
  int        words_sent  = 0;
  logic      quiet       = 1'b0;

  sha256_stream_hasher DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  sha256_stream_hasher_chk u_chk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_i  (out_word_o),
    .fail_cnt_o  (fail_cnt),
    .pending_o   (digests_owed)
  );

  always #5 clk_i = ~clk_i;

  // Offer one word, hold it until taken, then maybe leave a gap
  task automatic send_word(input logic [31:0] data, input logic [2:0] nb, input logic last);
    int gap;
    in_valid_i <= 1'b1;
    in_word_i  <= '{data_word: data, valid_bytes: nb, last_word: last};
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    words_sent++;
    quiet = (words_sent >= NUM_WORDS - QUIET_TAIL);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Mostly random data, with all-zero and all-one words mixed in
  function automatic logic [31:0] rand_data();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_message(input int body);
    for (int i = 0; i < body; i++) send_word(rand_data(), 3'($urandom_range(0, 7)), 1'b0);
    send_word(rand_data(), 3'($urandom_range(0, 7)), 1'b1);
  endtask

  // Digest side: long hold-off first so the block backs up, then random bursts
  initial begin
    int burst;
    wait (rst_ni);
    @(posedge clk_i);
    out_stall_i <= 1'b1;
    repeat (HOLD_CYC) @(posedge clk_i);
    forever begin
      if (quiet) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        burst = $urandom_range(1, 16);
        out_stall_i <= ($urandom_range(0, 2) == 0);
        repeat (burst) @(posedge clk_i);
      end
    end
  end

  // Stimulus and verdict
  initial begin
    int guard;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-word messages over every byte count: empty, partial, full, saturated
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word($urandom,      3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'h0000_0000, 3'd4, 1'b1);
    send_word(32'hffff_ffff, 3'd5, 1'b1);
    send_word(32'hffff_ffff, 3'd7, 1'b1);
    // full last word late in a block: the length no longer fits and needs
    // a further block, and the byte count on the body words is ignored
    for (int i = 0; i < 13; i++) send_word($urandom, 3'(i % 8), 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b1);

    // random messages, mostly short, some crossing several blocks
    while (words_sent < NUM_WORDS) begin
      if ($urandom_range(0, 5) == 0) send_message($urandom_range(16, 64));
      else send_message($urandom_range(0, 20));
    end
    in_valid_i <= 1'b0;

    // let the checker see the last word, then wait for the remaining digests
    @(posedge clk_i);
    guard = 0;
    while (digests_owed != 0 && guard < DRAIN_MAX) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYC) @(posedge clk_i);

    if (fail_cnt == 0 && digests_owed == 0) begin
      $display("[sha256_stream_hasher] OK");
    end else begin
      if (digests_owed != 0) $display("%0t: %0d digests never arrived", $time, digests_owed);
      $display("[sha256_stream_hasher] ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("[sha256_stream_hasher] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/sha256sh_pkg.sv
src/sha256sh_compress.sv
src/sha256_stream_hasher.sv
test/sha256_stream_hasher_chk.sv
test/sha256_stream_hasher_tb.sv
